// ===== hw/rtl/swcp_pkg.sv =====
package swcp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned CNT_W   = 2;
	localparam int unsigned PAY_W   = 4 * BYTE_W;
	localparam int unsigned TDATA_W = 64;

	localparam logic [WORD_W-1:0] SERVO_WORD_RST  = 16'h00ff;
	localparam logic [WORD_W-1:0] BRIGHT_WORD_RST = 16'h00fe;
	localparam logic [WORD_W-1:0] LED_WORD_RST    = 16'h00fd;
	localparam logic [WORD_W-1:0] CMD_WORD_RST    = 16'hffff;

	localparam logic [CIDX_W-1:0] REG_SERVO_WORD  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_BRIGHT_WORD = 2'd1;
	localparam logic [CIDX_W-1:0] REG_LED_WORD    = 2'd2;

	localparam logic [2:0] NEED_SERVO  = 3'd4;
	localparam logic [2:0] NEED_BRIGHT = 3'd1;
	localparam logic [2:0] NEED_LED    = 3'd3;

	typedef enum logic [CMD_W-1:0] {
		CMD_SERVO  = 2'd0,
		CMD_BRIGHT = 2'd1,
		CMD_LED    = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] servo_word;
		logic [WORD_W-1:0] brightness_word;
		logic [WORD_W-1:0] led_word;
	} cfg_words_t;

	typedef struct packed {
		cmd_t              command;
		logic [WORD_W-1:0] servo_first;
		logic [WORD_W-1:0] servo_second;
		logic [BYTE_W-1:0] brightness;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} res_t;

	typedef struct packed {
		logic valid;
		logic slot_free;
	} flow_t;

endpackage

// ===== hw/rtl/sync_word_command_parser.sv =====
// Channel    Direction  Payload
// s_axis     in         tdata[7:0] rx_byte
// m_axis     out        tdata[63:0] results, tuser[1:0] command
// cfg        in         cfg_index[1:0] register, cfg_data[15:0] value
//
// One byte per cycle unless m_axis stalls; the last byte goes through the input register
// and then the result register; throughput is set by the single input register feeding it.
// Reset loads the default command words and hunts for a fresh word.
// A stalled m_axis holds the result; the input register takes at most one more byte,
// then s_axis stalls until the result is taken. cfg_ready drops while a result waits.
module sync_word_command_parser
	import swcp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [BYTE_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// [15:0] servo_first, [31:16] servo_second, [39:32] brightness,
	// [47:40] red, [55:48] green, [63:56] blue
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic [CMD_W-1:0]   m_axis_tuser,  // [1:0] command
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [WORD_W-1:0]  cfg_data
);

	flow_t             flow;
	logic              advance;
	logic [BYTE_W-1:0] byte_s1;
	logic              res_valid;
	res_t              res;

	assign cfg_ready = !flow.valid;

	swcp_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.slot_free     (flow.slot_free),
		.advance       (advance),
		.byte_s1       (byte_s1)
	);

	swcp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	swcp_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.res_valid     (res_valid),
		.res           (res),
		.flow          (flow),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== hw/rtl/swcp_in_stage.sv =====
module swcp_in_stage
	import swcp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [BYTE_W-1:0] s_axis_tdata,
	input  logic              slot_free,
	output logic              advance,
	output logic [BYTE_W-1:0] byte_s1
);

	logic valid_s1;

	assign advance       = valid_s1 && slot_free;
	assign s_axis_tready = !valid_s1 || slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

endmodule

// ===== hw/rtl/swcp_core.sv =====
module swcp_core
	import swcp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0] cfg_data,
	input  logic              advance,
	input  logic [BYTE_W-1:0] byte_s1,
	output logic              res_valid,
	output res_t              res
);

	typedef enum logic [1:0] {
		PH_HIGH = 2'd0,
		PH_LOW  = 2'd1,
		PH_PAY  = 2'd2
	} phase_t;

	cfg_words_t        words_q;
	phase_t            phase_q, phase_d;
	logic [WORD_W-1:0] cmd_word_q, cmd_word_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [PAY_W-1:0]  pay_q, pay_d;
	logic [PAY_W-1:0]  merged;
	logic [2:0]        cnt_inc;
	logic [2:0]        need;
	logic              known;
	cmd_t              kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q.servo_word      <= SERVO_WORD_RST;
			words_q.brightness_word <= BRIGHT_WORD_RST;
			words_q.led_word        <= LED_WORD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SERVO_WORD:  words_q.servo_word      <= cfg_data;
				REG_BRIGHT_WORD: words_q.brightness_word <= cfg_data;
				REG_LED_WORD:    words_q.led_word        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign merged  = pay_q | (PAY_W'(byte_s1) << {count_q, 3'b000});
	assign cnt_inc = {1'b0, count_q} + 3'd1;

	always_comb begin
		priority if (cmd_word_q == words_q.servo_word) begin
			known = 1'b1;
			kind  = CMD_SERVO;
			need  = NEED_SERVO;
		end else if (cmd_word_q == words_q.brightness_word) begin
			known = 1'b1;
			kind  = CMD_BRIGHT;
			need  = NEED_BRIGHT;
		end else if (cmd_word_q == words_q.led_word) begin
			known = 1'b1;
			kind  = CMD_LED;
			need  = NEED_LED;
		end else begin
			known = 1'b0;
			kind  = CMD_SERVO;
			need  = NEED_SERVO;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		cmd_word_d = cmd_word_q;
		count_d    = count_q;
		pay_d      = pay_q;
		res_valid  = 1'b0;
		res        = '0;
		res.command = kind;
		unique case (phase_q)
			PH_LOW: begin
				cmd_word_d = {cmd_word_q[WORD_W-1:BYTE_W], byte_s1};
				phase_d    = PH_PAY;
				count_d    = '0;
				pay_d      = '0;
			end
			PH_PAY: begin
				if (!known) begin
					phase_d = PH_HIGH;
					count_d = '0;
					pay_d   = '0;
				end else if (cnt_inc >= need) begin
					res_valid = 1'b1;
					phase_d   = PH_HIGH;
					count_d   = '0;
					pay_d     = '0;
					unique case (kind)
						CMD_SERVO: begin
							res.servo_first  = merged[WORD_W-1:0];
							res.servo_second = merged[2*WORD_W-1:WORD_W];
						end
						CMD_BRIGHT: begin
							res.brightness = merged[BYTE_W-1:0];
						end
						default: begin
							res.red   = merged[BYTE_W-1:0];
							res.green = merged[2*BYTE_W-1:BYTE_W];
							res.blue  = merged[3*BYTE_W-1:2*BYTE_W];
						end
					endcase
				end else begin
					count_d = cnt_inc[CNT_W-1:0];
					pay_d   = merged;
				end
			end
			default: begin
				cmd_word_d = {byte_s1, {BYTE_W{1'b0}}};
				phase_d    = PH_LOW;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HIGH;
			cmd_word_q <= CMD_WORD_RST;
			count_q    <= '0;
			pay_q      <= '0;
		end else if (advance) begin
			phase_q    <= phase_d;
			cmd_word_q <= cmd_word_d;
			count_q    <= count_d;
			pay_q      <= pay_d;
		end
	end

endmodule

// ===== hw/rtl/swcp_out_reg.sv =====
module swcp_out_reg
	import swcp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               res_valid,
	input  res_t               res,
	output flow_t              flow,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic [CMD_W-1:0]   m_axis_tuser
);

	logic out_valid_q;
	res_t res_q;

	assign flow.valid     = out_valid_q;
	assign flow.slot_free = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.command;
	assign m_axis_tdata  = {res_q.blue, res_q.green, res_q.red, res_q.brightness,
		res_q.servo_second, res_q.servo_first};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

endmodule
